@@ rtl/hhv_pkg.sv @@
package hhv_pkg;

  // byte codes the parser reacts to
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // host byte count saturates at min(max host length, 255)
  localparam int unsigned MaxHostLen = 255;
  localparam logic [7:0]  HOST_CAP   = (MaxHostLen < 255) ? 8'(MaxHostLen) : 8'd255;

  // octet digit count saturates here
  localparam logic [2:0] V4_CNT_MAX = 3'd4;

  typedef enum logic [1:0] {
    SEC_HOST = 2'd0,
    SEC_IPV4 = 2'd1,
    SEC_PORT = 2'd2
  } section_e;

  typedef struct packed {
    section_e    section;
    logic        v4_dead;
    logic [1:0]  v4_oct;
    logic [2:0]  v4_cnt;
    logic [7:0]  prior;
    logic        rn_alive;
    logic [1:0]  pct;
    logic [7:0]  host_bytes;
    logic        failed;
  } hhv_state_t;

  typedef struct packed {
    logic        valid_res;
    logic [7:0]  host_length;
    logic        has_port;
    logic        host_is_ipv4;
  } hhv_result_t;

  localparam hhv_state_t STATE_RST = '{
    section:    SEC_HOST,
    v4_dead:    1'b0,
    v4_oct:     2'd0,
    v4_cnt:     3'd0,
    prior:      8'd0,
    rn_alive:   1'b1,
    pct:        2'd0,
    host_bytes: 8'd0,
    failed:     1'b0
  };

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  // unreserved and sub-delims
  function automatic logic is_regname_char(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
                     8'h2d, 8'h2e, 8'h5f, 8'h7e,
                     8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
                     8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d};
  endfunction

endpackage

@@ rtl/http_host_header_validator.sv @@
// Host header validator: one byte per word, a zero byte ends the value.
// Registers: an accepted word is loaded into the input register, and a terminator's
// result is loaded into the result register when the terminator advances, and is shown from there.
// Throughput: one word per cycle; a terminator waits only while an untaken
// result still sits in the result register, other bytes never wait.
// Reset: parser state returns to the start of a value, both registers empty.
module http_host_header_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [7:0] host_length_o,
  output logic       has_port_o,
  output logic       host_is_ipv4_o
);

  logic                 in_vld_q;
  logic [7:0]           char_q;
  hhv_pkg::hhv_state_t  st_q;
  hhv_pkg::hhv_state_t  st_d;
  hhv_pkg::hhv_result_t res_q;
  hhv_pkg::hhv_result_t res_d;
  logic                 out_vld_q;
  logic                 term;
  logic                 advance;

  hhv_step u_step (
    .char_i (char_q),
    .cur_i  (st_q),
    .nxt_o  (st_d),
    .term_o (term),
    .res_o  (res_d)
  );

  // a word moves on unless its result would overwrite a waiting one
  assign advance    = in_vld_q && (!term || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hhv_pkg::STATE_RST;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && term) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && term) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign valid_res_o    = res_q.valid_res;
  assign host_length_o  = res_q.host_length;
  assign has_port_o     = res_q.has_port;
  assign host_is_ipv4_o = res_q.host_is_ipv4;

endmodule

@@ rtl/hhv_step.sv @@
module hhv_step (
  input  logic [7:0]          char_i,
  input  hhv_pkg::hhv_state_t cur_i,
  output hhv_pkg::hhv_state_t nxt_o,
  output logic                term_o,
  output hhv_pkg::hhv_result_t res_o
);

  logic       octet_ok;
  logic       fit;
  logic [3:0] dig;
  logic [3:0] d1;
  logic [3:0] d2;
  logic [7:0] tk_prior;
  logic [2:0] tk_cnt;
  logic [7:0] host_inc;
  logic       valid;
  logic       committed;

  // digit value and current octet status
  assign dig      = char_i[3:0];
  assign d1       = cur_i.prior[7:4];
  assign d2       = cur_i.prior[3:0];
  assign octet_ok = (cur_i.v4_cnt == 3'd1) || (cur_i.v4_cnt == 3'd2) ||
                    ((cur_i.v4_cnt == 3'd3) && (cur_i.prior == 8'd1));
  assign fit      = (d1 == 4'd1) ||
                    ((d1 == 4'd2) && ((d2 <= 4'd4) || ((d2 == 4'd5) && (dig <= 4'd5))));
  assign committed = !cur_i.v4_dead && (cur_i.v4_oct == 2'd3) && (cur_i.v4_cnt != 3'd0);
  assign host_inc = (cur_i.host_bytes < hhv_pkg::HOST_CAP) ? cur_i.host_bytes + 8'd1
                                                            : cur_i.host_bytes;

  // effect of one more octet digit
  always_comb begin
    case (cur_i.v4_cnt)
      3'd0:    tk_prior = {dig, 4'd0};
      3'd1:    tk_prior = cur_i.prior | {4'd0, dig};
      3'd2:    tk_prior = fit ? 8'd1 : 8'd0;
      default: tk_prior = cur_i.prior;
    endcase
    tk_cnt = (cur_i.v4_cnt < hhv_pkg::V4_CNT_MAX) ? cur_i.v4_cnt + 3'd1
                                                  : hhv_pkg::V4_CNT_MAX;
  end

  // verdict on the terminator
  always_comb begin
    case (cur_i.section)
      hhv_pkg::SEC_PORT: valid = 1'b1;
      hhv_pkg::SEC_IPV4: valid = octet_ok;
      hhv_pkg::SEC_HOST: valid = cur_i.rn_alive && (cur_i.pct == 2'd0);
      default:           valid = 1'b0;
    endcase
    if (cur_i.failed) begin
      valid = 1'b0;
    end
    term_o             = (char_i == hhv_pkg::CH_NUL);
    res_o.valid_res    = valid;
    res_o.host_length  = valid ? cur_i.host_bytes : 8'd0;
    res_o.has_port     = valid && (cur_i.section == hhv_pkg::SEC_PORT);
    res_o.host_is_ipv4 = valid && ((cur_i.section == hhv_pkg::SEC_IPV4) ||
                                   ((cur_i.section == hhv_pkg::SEC_PORT) && committed));
  end

  // state update for one word
  always_comb begin
    nxt_o = cur_i;
    if (char_i == hhv_pkg::CH_NUL) begin
      nxt_o = hhv_pkg::STATE_RST;
    end else if (!cur_i.failed) begin
      case (cur_i.section)
        hhv_pkg::SEC_PORT: begin
          if (!hhv_pkg::is_digit(char_i)) begin
            nxt_o.failed = 1'b1;
          end
        end
        hhv_pkg::SEC_IPV4: begin
          if (hhv_pkg::is_digit(char_i)) begin
            nxt_o.prior      = tk_prior;
            nxt_o.v4_cnt     = tk_cnt;
            nxt_o.host_bytes = host_inc;
          end else if ((char_i == hhv_pkg::CH_COLON) && octet_ok) begin
            nxt_o.section = hhv_pkg::SEC_PORT;
          end else begin
            nxt_o.failed = 1'b1;
          end
        end
        hhv_pkg::SEC_HOST: begin
          if (char_i == hhv_pkg::CH_COLON) begin
            nxt_o.v4_dead = 1'b1;
            if (cur_i.rn_alive && (cur_i.pct == 2'd0)) begin
              nxt_o.section = hhv_pkg::SEC_PORT;
            end else begin
              nxt_o.failed = 1'b1;
            end
          end else begin
            // dotted address track
            if (!cur_i.v4_dead) begin
              if (hhv_pkg::is_digit(char_i)) begin
                nxt_o.prior  = tk_prior;
                nxt_o.v4_cnt = tk_cnt;
                if (cur_i.v4_oct == 2'd3) begin
                  nxt_o.section = hhv_pkg::SEC_IPV4;
                end
              end else if ((char_i == hhv_pkg::CH_DOT) && (cur_i.v4_oct != 2'd3) &&
                           octet_ok) begin
                nxt_o.prior  = 8'd0;
                nxt_o.v4_oct = cur_i.v4_oct + 2'd1;
                nxt_o.v4_cnt = 3'd0;
              end else begin
                nxt_o.v4_dead = 1'b1;
              end
            end
            // reg-name track with percent escapes
            if (cur_i.pct != 2'd0) begin
              if (hhv_pkg::is_hex(char_i)) begin
                nxt_o.pct = (cur_i.pct == 2'd1) ? 2'd2 : 2'd0;
              end else begin
                nxt_o.rn_alive = 1'b0;
              end
            end else if (char_i == hhv_pkg::CH_PERCENT) begin
              nxt_o.pct = 2'd1;
            end else if (!hhv_pkg::is_regname_char(char_i)) begin
              nxt_o.rn_alive = 1'b0;
            end
            nxt_o.host_bytes = host_inc;
            if ((nxt_o.section == hhv_pkg::SEC_HOST) && !nxt_o.rn_alive && nxt_o.v4_dead) begin
              nxt_o.failed = 1'b1;
            end
          end
        end
        default: begin
          nxt_o.failed = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

  // tracks the parse of each host value and holds the verdicts still owed
  class host_verdict_board;
    hhv_pkg::section_e    sec;
    bit                   v4_dead;
    logic [1:0]           v4_oct;
    logic [2:0]           v4_cnt;
    logic [7:0]           prior;
    bit                   rn_alive;
    logic [1:0]           pct;
    logic [7:0]           hbytes;
    bit                   failed;
    hhv_pkg::hhv_result_t due[$];
    int                   mismatches;
    int                   verdicts;
    int                   valid_cnt;
    int                   ipv4_cnt;
    int                   port_cnt;

    function new();
      mismatches = 0;
      verdicts   = 0;
      valid_cnt  = 0;
      ipv4_cnt   = 0;
      port_cnt   = 0;
      restart();
    endfunction

    function void restart();
      sec      = hhv_pkg::SEC_HOST;
      v4_dead  = 1'b0;
      v4_oct   = 2'd0;
      v4_cnt   = 3'd0;
      prior    = 8'd0;
      rn_alive = 1'b1;
      pct      = 2'd0;
      hbytes   = 8'd0;
      failed   = 1'b0;
    endfunction

    function bit is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_hexd(logic [7:0] c);
      return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // unreserved plus sub-delims
    function bit is_host_char(logic [7:0] c);
      if (is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return 1'b1;
      case (c)
        "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=":
          return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit octet_ok();
      return v4_cnt == 3'd1 || v4_cnt == 3'd2 || (v4_cnt == 3'd3 && prior == 8'd1);
    endfunction

    // greedy octet: remember two digits, then whether a three-digit form fits
    function void take_digit(logic [7:0] c);
      logic [3:0] d;
      logic [3:0] hi;
      logic [3:0] lo;
      bit fit;
      d  = c[3:0];
      hi = prior[7:4];
      lo = prior[3:0];
      case (v4_cnt)
        3'd0: prior = {d, 4'h0};
        3'd1: prior[3:0] = d;
        3'd2: begin
          fit = hi == 4'd1 || (hi == 4'd2 && (lo <= 4'd4 || (lo == 4'd5 && d <= 4'd5)));
          prior = fit ? 8'd1 : 8'd0;
        end
        default: ;
      endcase
      if (v4_cnt < hhv_pkg::V4_CNT_MAX) v4_cnt = v4_cnt + 3'd1;
    endfunction

    function void count_host();
      if (hbytes < hhv_pkg::HOST_CAP) hbytes = hbytes + 8'd1;
    endfunction

    // accepted input word
    function void note_byte(logic [7:0] c);
      hhv_pkg::hhv_result_t want;
      bit ok;
      logic [1:0] oct;
      if (c == hhv_pkg::CH_NUL) begin
        if (failed) ok = 1'b0;
        else if (sec == hhv_pkg::SEC_PORT) ok = 1'b1;
        else if (sec == hhv_pkg::SEC_IPV4) ok = octet_ok();
        else ok = rn_alive && pct == 2'd0;
        want.valid_res    = ok;
        want.host_length  = ok ? hbytes : 8'd0;
        want.has_port     = ok && sec == hhv_pkg::SEC_PORT;
        want.host_is_ipv4 = ok && (sec == hhv_pkg::SEC_IPV4 ||
                            (sec == hhv_pkg::SEC_PORT && !v4_dead && v4_oct == 2'd3 &&
                             v4_cnt != 3'd0));
        due.push_back(want);
        restart();
        return;
      end
      if (failed) return;
      case (sec)
        hhv_pkg::SEC_PORT: if (!is_dec(c)) failed = 1'b1;
        hhv_pkg::SEC_IPV4: begin
          if (is_dec(c)) begin
            take_digit(c);
            count_host();
          end else if (c == hhv_pkg::CH_COLON && octet_ok()) begin
            sec = hhv_pkg::SEC_PORT;
          end else begin
            failed = 1'b1;
          end
        end
        hhv_pkg::SEC_HOST: begin
          // colon closes the host, ipv4 can no longer be committed
          if (c == hhv_pkg::CH_COLON) begin
            v4_dead = 1'b1;
            if (rn_alive && pct == 2'd0) sec = hhv_pkg::SEC_PORT;
            else failed = 1'b1;
            return;
          end
          if (!v4_dead) begin
            oct = v4_oct;
            if (is_dec(c)) begin
              take_digit(c);
              if (oct == 2'd3) sec = hhv_pkg::SEC_IPV4;
            end else if (c == hhv_pkg::CH_DOT && oct < 2'd3 && octet_ok()) begin
              prior  = 8'd0;
              v4_oct = oct + 2'd1;
              v4_cnt = 3'd0;
            end else begin
              v4_dead = 1'b1;
            end
          end
          // reg-name with percent escapes
          if (pct != 2'd0) begin
            if (is_hexd(c)) pct = (pct == 2'd1) ? 2'd2 : 2'd0;
            else rn_alive = 1'b0;
          end else if (c == hhv_pkg::CH_PERCENT) begin
            pct = 2'd1;
          end else if (!is_host_char(c)) begin
            rn_alive = 1'b0;
          end
          count_host();
          if (sec == hhv_pkg::SEC_HOST && !rn_alive && v4_dead) failed = 1'b1;
        end
        default: failed = 1'b1;
      endcase
    endfunction

    function bit field_ok(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b1;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      return 1'b0;
    endfunction

    // accepted result word against the oldest verdict owed
    function void check_verdict(hhv_pkg::hhv_result_t got);
      hhv_pkg::hhv_result_t want;
      bit bad;
      if (due.size() == 0) begin
        $display("%0t: result with none expected, actual valid %0d len %0d port %0d ipv4 %0d",
                 $time, got.valid_res, got.host_length, got.has_port, got.host_is_ipv4);
        mismatches++;
        return;
      end
      want = due.pop_front();
      bad = !field_ok("valid_res", want.valid_res, got.valid_res) |
            !field_ok("host_length", want.host_length, got.host_length) |
            !field_ok("has_port", want.has_port, got.has_port) |
            !field_ok("host_is_ipv4", want.host_is_ipv4, got.host_is_ipv4);
      if (bad) mismatches++;
      verdicts++;
      if (got.valid_res) valid_cnt++;
      if (got.host_is_ipv4) ipv4_cnt++;
      if (got.has_port) port_cnt++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] char_code = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       valid_res;
  logic [7:0] host_length;
  logic       has_port;
  logic       host_is_ipv4;

  host_verdict_board sb;
  logic [7:0] text[$];
  int send_idle = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int values_sent = 0;
  int idle_tbl[4] = '{0, 68, 0, 11};
  int stall_tbl[4] = '{0, 0, 68, 11};

  http_host_header_validator dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .valid_res_o    (valid_res),
    .host_length_o  (host_length),
    .has_port_o     (has_port),
    .host_is_ipv4_o (host_is_ipv4)
  );

  always #6 clk = ~clk;

  // one word per call, entered and left at a falling edge
  task automatic send_word(input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_value();
    foreach (text[i]) send_word(text[i]);
    send_word(hhv_pkg::CH_NUL);
    values_sent++;
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic add_octet();
    int n;
    n = $urandom_range(255);
    case ($urandom_range(9))
      0: add_str($sformatf("0%0d", n % 10));
      1: begin
        text.push_back(8'("0" + n / 100));
        text.push_back(8'("0" + n / 10 % 10));
        text.push_back(8'("0" + n % 10));
      end
      2: add_str($sformatf("%0d%0d", n, $urandom_range(9)));
      default: add_str($sformatf("%0d", n));
    endcase
  endtask

  task automatic add_port();
    int len;
    if ($urandom_range(1) == 0) return;
    text.push_back(hhv_pkg::CH_COLON);
    len = $urandom_range(5);
    repeat (len) text.push_back(8'("0" + $urandom_range(9)));
  endtask

  // kind 0 is a long host, 1..9 noise, the rest ipv4 or reg-name forms
  task automatic build_value(input int kind);
    string host_alpha;
    string hex_alpha;
    int len;
    int cnt;
    host_alpha = "abcmxyzAKZ0459-._~!$&'()*+,;=";
    hex_alpha  = "0123456789abcdefABCDEFgG:";
    text.delete();
    if (kind == 0) begin
      len = $urandom_range(250, 280);
      repeat (len) text.push_back(8'("a" + $urandom_range(25)));
      add_port();
    end else if (kind < 10) begin
      len = $urandom_range(8);
      repeat (len) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(1) == 0) begin
        cnt = ($urandom_range(5) == 0) ? $urandom_range(3, 5) : 4;
        for (int k = 0; k < cnt; k++) begin
          if (k != 0) text.push_back(hhv_pkg::CH_DOT);
          add_octet();
        end
      end else begin
        len = $urandom_range(12);
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            text.push_back(hhv_pkg::CH_PERCENT);
            text.push_back(hex_alpha[$urandom_range(hex_alpha.len() - 1)]);
            if ($urandom_range(7) != 0)
              text.push_back(hex_alpha[$urandom_range(hex_alpha.len() - 1)]);
          end else begin
            text.push_back(host_alpha[$urandom_range(host_alpha.len() - 1)]);
          end
        end
      end
      add_port();
      // damage one byte now and then
      if (text.size() != 0 && $urandom_range(99) < 20)
        text[$urandom_range(text.size() - 1)] = 8'($urandom_range(1, 255));
    end
  endtask

  // receiver readiness, with an optional long hold counted here
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    hhv_pkg::hhv_result_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.valid_res    = valid_res;
      got.host_length  = host_length;
      got.has_port     = has_port;
      got.host_is_ipv4 = host_is_ipv4;
      sb.check_verdict(got);
    end
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int budget;
    sb = new();
    repeat (7) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // directed: empty value, high byte, ipv4 with empty port, escape, bad port
    text.delete();
    send_value();
    text.delete();
    text.push_back(8'hff);
    send_value();
    text.delete();
    add_str("1.2.3.4:");
    send_value();
    text.delete();
    add_str("a%2F:9");
    send_value();
    text.delete();
    add_str("a:x");
    send_value();

    // output held off while short values keep coming
    hold_request = 400;
    repeat (30) begin
      text.delete();
      add_str(($urandom_range(1) == 0) ? "ab" : "7.7.7.7");
      send_value();
    end

    for (int p = 0; p < 4; p++) begin
      send_idle = idle_tbl[p];
      stall_pct = stall_tbl[p];
      budget = bytes_sent + 210;
      if (p == 0) begin
        build_value(0);
        send_value();
      end
      while (bytes_sent < budget) begin
        build_value($urandom_range(99));
        send_value();
      end
    end

    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d values over four idle/stall mixes and one long output hold",
             bytes_sent, values_sent);
    $display("checked %0d verdicts: %0d valid, %0d ipv4, %0d with port, %0d mismatching",
             sb.verdicts, sb.valid_cnt, sb.ipv4_cnt, sb.port_cnt, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
